@@ rtl/cbb_pkg.sv @@
package cbb_pkg;

    // Widths of the item fields and of the configuration port.
    localparam int PIXEL_W  = 8;
    localparam int COORD_W  = 12;
    localparam int EXTENT_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Register reset values and the width padding step.
    localparam logic [EXTENT_W-1:0] RESET_FRAME_WIDTH  = 13'd4096;
    localparam logic [EXTENT_W-1:0] RESET_FRAME_HEIGHT = 13'd4096;
    localparam logic [PIXEL_W-1:0]  RESET_THRESHOLD    = 8'd234;
    localparam int                  PAD_STEP           = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH    = 2'd0,
        REG_FRAME_HEIGHT   = 2'd1,
        REG_DARK_THRESHOLD = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
    } t_pixel_item;

    typedef struct packed {
        logic [COORD_W-1:0]  box_left;
        logic [COORD_W-1:0]  box_top;
        logic [EXTENT_W-1:0] box_width;
        logic [EXTENT_W-1:0] box_height;
        logic                frame_empty;
    } t_box_item;

    typedef struct packed {
        t_cfg_reg              reg_idx;
        logic [CFG_DATA_W-1:0] wdata;
    } t_cfg_item;

endpackage

@@ rtl/cbb_stream_if.sv @@
interface cbb_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/content_bounding_box_unit.sv @@
// Content bounding box for automatic cropping. Grey pixels arrive one item per
// cycle in raster order with no row padding; a pixel at or below the dark
// threshold counts as content. After the last pixel of each frame the block
// delivers one result item holding the left column, top row, height and a
// width padded up to the next multiple of four (taken back by four when the
// padded box would run past the right edge of the frame). A frame with no
// content gives zeros and sets frame_empty. The block takes one pixel per
// clock: the compare and the min/max update sit between the counters and a
// snapshot register, and the box arithmetic sits between the snapshot and the
// output register, through both of which each result passes. The input is
// only held back when a finished result is waiting both in the snapshot and
// in the output register, which at one result per frame does not happen
// unless the sink stalls for a whole frame. Configuration writes are always
// accepted and should be made between frames; frame sizes of zero are treated
// as one and sizes above MAX_WIDTH or MAX_HEIGHT as those maxima.
module content_bounding_box_unit #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cbb_stream_if.sink   i_pix,
    cbb_stream_if.sink   i_cfg,
    cbb_stream_if.source o_box
);
    import cbb_pkg::*;

    // Column and row counter widths, and widths able to hold the sizes.
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT + 1) : 1;

    typedef struct packed {
        logic [CW-1:0] lc;
        logic [CW-1:0] gc;
        logic [RW-1:0] lr;
        logic [RW-1:0] gr;
        logic          seen;
        logic [WW-1:0] w;
    } t_snap;

    // Configuration registers.
    logic [EXTENT_W-1:0] r_frame_width;
    logic [EXTENT_W-1:0] r_frame_height;
    logic [PIXEL_W-1:0]  r_threshold;

    // Scan state.
    logic [CW-1:0] r_col, r_lc, r_gc;
    logic [RW-1:0] r_row, r_lr, r_gr;
    logic          r_seen;

    // Frame snapshot and output register.
    t_snap     r_snap;
    logic      r_snap_valid;
    t_box_item r_out;
    logic      r_out_valid;

    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic          pix_acc, cfg_acc, out_load;
    logic          is_dark, row_end, frame_end;
    logic [CW-1:0] n_lc, n_gc;
    logic [RW-1:0] n_lr, n_gr;
    logic          n_seen;
    t_box_item     n_out;

    // ------------------------------------------------------------------
    // Configuration port: every write is taken; unknown indexes are dropped.
    // ------------------------------------------------------------------
    assign i_cfg.ready = 1'b1;
    assign cfg_acc     = i_cfg.valid && i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RESET_FRAME_WIDTH;
            r_frame_height <= RESET_FRAME_HEIGHT;
            r_threshold    <= RESET_THRESHOLD;
        end else if (cfg_acc) begin
            unique case (i_cfg.data.reg_idx)
                REG_FRAME_WIDTH:    r_frame_width  <= i_cfg.data.wdata;
                REG_FRAME_HEIGHT:   r_frame_height <= i_cfg.data.wdata;
                REG_DARK_THRESHOLD: r_threshold    <= i_cfg.data.wdata[PIXEL_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective frame size: zero reads as one, large values saturate.
    always_comb begin
        if (r_frame_width == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            h_eff = HW'(1);
        end else if (32'(r_frame_height) > 32'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(r_frame_height);
        end
    end

    // ------------------------------------------------------------------
    // Scan stage: threshold compare, extent update and raster counters.
    // A row or frame ends once the counter reaches or passes its last
    // index, so a size shrunk mid-frame takes effect at once.
    // ------------------------------------------------------------------
    assign pix_acc   = i_pix.valid && i_pix.ready;
    assign is_dark   = i_pix.data.pixel <= r_threshold;
    assign row_end   = ((WW+1)'(r_col) + (WW+1)'(1)) >= (WW+1)'(w_eff);
    assign frame_end = row_end && (((HW+1)'(r_row) + (HW+1)'(1)) >= (HW+1)'(h_eff));

    always_comb begin
        n_lc   = r_lc;
        n_gc   = r_gc;
        n_lr   = r_lr;
        n_gr   = r_gr;
        n_seen = r_seen;
        if (is_dark) begin
            if (!r_seen || r_col < r_lc) begin
                n_lc = r_col;
            end
            if (!r_seen || r_col > r_gc) begin
                n_gc = r_col;
            end
            if (!r_seen || r_row < r_lr) begin
                n_lr = r_row;
            end
            if (!r_seen || r_row > r_gr) begin
                n_gr = r_row;
            end
            n_seen = 1'b1;
        end
    end

    // A frame-end pixel needs the snapshot free, or freed this cycle.
    assign i_pix.ready = !r_snap_valid || out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_lc   <= '1;
            r_gc   <= '0;
            r_lr   <= '1;
            r_gr   <= '0;
            r_seen <= 1'b0;
        end else if (pix_acc) begin
            if (!row_end) begin
                r_col <= r_col + CW'(1);
            end else begin
                r_col <= '0;
                r_row <= frame_end ? '0 : r_row + RW'(1);
            end
            if (frame_end) begin
                // Reload the extents for the next frame.
                r_lc   <= '1;
                r_gc   <= '0;
                r_lr   <= '1;
                r_gr   <= '0;
                r_seen <= 1'b0;
            end else begin
                r_lc   <= n_lc;
                r_gc   <= n_gc;
                r_lr   <= n_lr;
                r_gr   <= n_gr;
                r_seen <= n_seen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (pix_acc && frame_end) begin
            r_snap_valid <= 1'b1;
        end else if (out_load) begin
            r_snap_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_acc && frame_end) begin
            r_snap <= '{lc: n_lc, gc: n_gc, lr: n_lr, gr: n_gr, seen: n_seen, w: w_eff};
        end
    end

    // ------------------------------------------------------------------
    // Box stage: span, padding to a multiple of four, right-edge rule.
    // ------------------------------------------------------------------
    always_comb begin
        logic [CW:0]   span;
        logic [CW+1:0] padded;
        logic [CW+2:0] reach;
        logic [RW:0]   rows;
        logic [31:0]   lc32, lr32, pad32, rows32;

        span   = (CW+1)'(r_snap.gc) - (CW+1)'(r_snap.lc) + (CW+1)'(1);
        // span + 4 - span % 4 is span with its low two bits cleared, plus four.
        padded = (CW+2)'({span[CW:2], 2'b00}) + (CW+2)'(PAD_STEP);
        reach  = (CW+3)'(padded) + (CW+3)'(r_snap.gc);
        if (reach > (CW+3)'(r_snap.w)) begin
            padded = padded - (CW+2)'(PAD_STEP);
        end
        rows   = (RW+1)'(r_snap.gr) - (RW+1)'(r_snap.lr) + (RW+1)'(1);
        lc32   = 32'(r_snap.lc);
        lr32   = 32'(r_snap.lr);
        pad32  = 32'(padded);
        rows32 = 32'(rows);

        if (r_snap.seen) begin
            n_out.box_left    = lc32[COORD_W-1:0];
            n_out.box_top     = lr32[COORD_W-1:0];
            n_out.box_width   = pad32[EXTENT_W-1:0];
            n_out.box_height  = rows32[EXTENT_W-1:0];
            n_out.frame_empty = 1'b0;
        end else begin
            n_out.box_left    = '0;
            n_out.box_top     = '0;
            n_out.box_width   = '0;
            n_out.box_height  = '0;
            n_out.frame_empty = 1'b1;
        end
    end

    assign out_load = r_snap_valid && (!r_out_valid || o_box.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_box.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_box.valid = r_out_valid;
    assign o_box.data  = r_out;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // A frame end is never accepted while a finished snapshot would be lost.
    a_snap_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pix_acc && frame_end) |-> (!r_snap_valid || out_load))
        else $error("frame snapshot overwritten");

    // A new result only appears after a snapshot was waiting.
    a_out_from_snap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_snap_valid))
        else $error("result without a frame snapshot");

    // An empty frame reports a zero box.
    a_empty_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_box.valid && o_box.data.frame_empty) |->
            (o_box.data.box_width == '0 && o_box.data.box_height == '0 &&
             o_box.data.box_left == '0 && o_box.data.box_top == '0))
        else $error("empty frame with non-zero box");

endmodule

@@ tb/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cbb_pkg::*;

    // The block is built at its default maximum frame size, and the checker
    // below clamps the frame size registers to the same limits.
    localparam int MAX_WIDTH     = 4096;
    localparam int MAX_HEIGHT    = 4096;
    localparam int RANDOM_PIXELS = 1300;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_OFF      = 400;

    // Index 3 names no register. A write to it must leave every setting alone.
    localparam t_cfg_reg REG_SPARE = t_cfg_reg'(2'd3);

    localparam logic [PIXEL_W-1:0] WHITE = 8'd255;
    localparam logic [PIXEL_W-1:0] BLACK = 8'd0;

    // Tracks the frame position and the content extremes exactly as the block
    // should, and keeps the crop boxes that are owed but not yet delivered.
    class crop_box_tracker;
        logic [EXTENT_W-1:0] width_reg;
        logic [EXTENT_W-1:0] height_reg;
        logic [PIXEL_W-1:0]  threshold_reg;
        logic [COORD_W-1:0]  col;
        logic [COORD_W-1:0]  row;
        logic [COORD_W-1:0]  left;
        logic [COORD_W-1:0]  right;
        logic [COORD_W-1:0]  top;
        logic [COORD_W-1:0]  bottom;
        bit                  content_seen;
        t_box_item           boxes_due[$];
        int                  mismatches;

        function new();
            width_reg     = RESET_FRAME_WIDTH;
            height_reg    = RESET_FRAME_HEIGHT;
            threshold_reg = RESET_THRESHOLD;
            col           = '0;
            row           = '0;
            mismatches    = 0;
            start_frame();
        endfunction

        function void start_frame();
            left         = '1;
            right        = '0;
            top          = '1;
            bottom       = '0;
            content_seen = 1'b0;
        endfunction

        // A size of zero counts as one, and anything above the maximum as the
        // maximum.
        function int usable_size(logic [EXTENT_W-1:0] value, int limit);
            if (int'(value) == 0) begin
                return 1;
            end
            if (int'(value) > limit) begin
                return limit;
            end
            return int'(value);
        endfunction

        function void load_register(t_cfg_reg idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_FRAME_WIDTH: begin
                    width_reg = value[EXTENT_W-1:0];
                end
                REG_FRAME_HEIGHT: begin
                    height_reg = value[EXTENT_W-1:0];
                end
                REG_DARK_THRESHOLD: begin
                    threshold_reg = value[PIXEL_W-1:0];
                end
                default: begin
                end
            endcase
        endfunction

        function void take_pixel(logic [PIXEL_W-1:0] pixel);
            int        w;
            int        h;
            int        span;
            int        padded;
            t_box_item box;
            w = usable_size(width_reg, MAX_WIDTH);
            h = usable_size(height_reg, MAX_HEIGHT);

            if (pixel <= threshold_reg) begin
                if (!content_seen || col < left) begin
                    left = col;
                end
                if (!content_seen || col > right) begin
                    right = col;
                end
                if (!content_seen || row < top) begin
                    top = row;
                end
                if (!content_seen || row > bottom) begin
                    bottom = row;
                end
                content_seen = 1'b1;
            end

            // A shrunk size takes effect at once, so a counter that already
            // sits at or past the new last index ends its row or frame here.
            if (int'(col) + 1 < w) begin
                col = col + COORD_W'(1);
                return;
            end
            col = '0;
            if (int'(row) + 1 < h) begin
                row = row + COORD_W'(1);
                return;
            end
            row = '0;

            box = '0;
            if (!content_seen) begin
                box.frame_empty = 1'b1;
            end else begin
                // The width always grows to the next multiple of four, even
                // when it is one already, and gives four back when the padded
                // box would run past the right edge.
                span   = int'(right) - int'(left) + 1;
                padded = span + PAD_STEP - (span % PAD_STEP);
                if (padded + int'(right) > w) begin
                    padded = padded - PAD_STEP;
                end
                box.box_left   = left;
                box.box_top    = top;
                box.box_width  = padded[EXTENT_W-1:0];
                box.box_height = EXTENT_W'(bottom) - EXTENT_W'(top) + EXTENT_W'(1);
            end
            boxes_due.push_back(box);
            start_frame();
        endfunction

        function void compare_field(string field, logic [EXTENT_W-1:0] want,
                                    logic [EXTENT_W-1:0] got);
            if (got !== want) begin
                mismatches++;
                $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            end
        endfunction

        function void check_box(t_box_item got);
            t_box_item want;
            if (boxes_due.size() == 0) begin
                mismatches++;
                $display({"%0t: box expected none, got left %0d top %0d ",
                          "width %0d height %0d empty %0b"},
                         $time, got.box_left, got.box_top, got.box_width,
                         got.box_height, got.frame_empty);
                return;
            end
            want = boxes_due.pop_front();
            compare_field("box_left", EXTENT_W'(want.box_left), EXTENT_W'(got.box_left));
            compare_field("box_top", EXTENT_W'(want.box_top), EXTENT_W'(got.box_top));
            compare_field("box_width", want.box_width, got.box_width);
            compare_field("box_height", want.box_height, got.box_height);
            compare_field("frame_empty", EXTENT_W'(want.frame_empty),
                          EXTENT_W'(got.frame_empty));
        endfunction

        function int boxes_pending();
            return boxes_due.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    cbb_stream_if #(.T(t_pixel_item)) pix_if ();
    cbb_stream_if #(.T(t_cfg_item))   cfg_if ();
    cbb_stream_if #(.T(t_box_item))   box_if ();

    crop_box_tracker tracker = new();

    // Idling limits for the two sides, changed from one phase to the next.
    // A hold-off request is picked up by the box sink at its next item.
    int               pix_gap_max     = 5;
    int               box_gap_max     = 5;
    int               box_hold_cycles = 0;
    int               cycle_count     = 0;
    logic [PIXEL_W-1:0] threshold_now = RESET_THRESHOLD;

    content_bounding_box_unit #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .i_cfg   (cfg_if),
        .o_box   (box_if)
    );

    always #1 i_clk = ~i_clk;

    // The whole run is bounded, so that a lost box or a stuck handshake ends
    // in a failure rather than a hang.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // All three channels are watched at the rising edge. A pixel taken at an
    // edge sees the settings from before that edge, so it is noted ahead of a
    // register write at the same edge, and a box is checked last.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pix_if.valid && pix_if.ready) begin
                tracker.take_pixel(pix_if.data.pixel);
            end
            if (cfg_if.valid && cfg_if.ready) begin
                tracker.load_register(cfg_if.data.reg_idx, cfg_if.data.wdata);
            end
            if (box_if.valid && box_if.ready) begin
                tracker.check_box(box_if.data);
            end
        end
    end

    // Box sink. Before each item it waits a random number of cycles with ready
    // low, or the full hold-off when one has been requested, and then keeps
    // ready high until an item is taken.
    initial begin
        int gap;
        box_if.ready = 1'b0;
        while (i_rst_n !== 1'b1) begin
            @(posedge i_clk);
        end
        forever begin
            @(negedge i_clk);
            if (box_hold_cycles > 0) begin
                gap = box_hold_cycles;
                box_hold_cycles = 0;
            end else begin
                gap = $urandom_range(0, box_gap_max);
            end
            if (gap > 0) begin
                box_if.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            box_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(box_if.valid && box_if.ready));
        end
    end

    // Offers one pixel item after a random gap. Valid stays high after the
    // handshake, so a following item with no gap goes out back to back.
    task automatic send_pixel(input logic [PIXEL_W-1:0] value);
        int gap;
        gap = $urandom_range(0, pix_gap_max);
        @(negedge i_clk);
        if (gap > 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pix_if.valid     <= 1'b1;
        pix_if.data.pixel <= value;
        do @(posedge i_clk); while (!(pix_if.valid && pix_if.ready));
    endtask

    task automatic set_register(input t_cfg_reg idx, input int value);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= '{reg_idx: idx, wdata: value[CFG_DATA_W-1:0]};
        do @(posedge i_clk); while (!(cfg_if.valid && cfg_if.ready));
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Stops offering pixels and waits until every box owed has been taken and
    // the two pipeline stages behind the counters are certain to be empty.
    task automatic settle();
        @(negedge i_clk);
        pix_if.valid <= 1'b0;
        while (tracker.boxes_pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input int width, input int height, input int threshold);
        settle();
        set_register(REG_FRAME_WIDTH, width);
        set_register(REG_FRAME_HEIGHT, height);
        set_register(REG_DARK_THRESHOLD, threshold);
        threshold_now = threshold[PIXEL_W-1:0];
    endtask

    // Content pixels are drawn at or below the current threshold, background
    // pixels above it, unless the frame takes any grey level at all.
    function automatic logic [PIXEL_W-1:0] pick_pixel(int dark_permille, bit any_value);
        if (any_value) begin
            return PIXEL_W'($urandom_range(0, 255));
        end
        if ($urandom_range(0, 999) < dark_permille) begin
            return PIXEL_W'($urandom_range(0, threshold_now));
        end
        if (threshold_now == WHITE) begin
            return WHITE;
        end
        return PIXEL_W'($urandom_range(int'(threshold_now) + 1, 255));
    endfunction

    // Each frame gets its own density of content, from none at all to every
    // pixel, so that empty frames, single points and full boxes all occur.
    task automatic send_frames(input int frame_pixels, input int frames);
        int dark_permille;
        bit any_value;
        repeat (frames) begin
            any_value = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 4))
                0: dark_permille = 0;
                1: dark_permille = (frame_pixels > 256) ? 2 : 30;
                2: dark_permille = 200;
                3: dark_permille = 700;
                default: dark_permille = 1000;
            endcase
            repeat (frame_pixels) send_pixel(pick_pixel(dark_permille, any_value));
        end
    endtask

    initial begin
        int phase_no;
        int small_pixels;
        int width;
        int height;
        int frames;
        int thr;

        pix_if.valid = 1'b0;
        pix_if.data  = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '{reg_idx: REG_FRAME_WIDTH, wdata: '0};
        i_rst_n      = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames on a four by two grid. The first holds no content
        // at all and must come back empty with a zero box.
        configure(4, 2, RESET_THRESHOLD);
        repeat (8) send_pixel(WHITE);

        // One pixel just above the threshold, which is background, and one at
        // the threshold itself in the last column. The padded width of four
        // would pass the right edge, so it is taken back to zero.
        send_pixel(RESET_THRESHOLD + 1'b1);
        repeat (6) send_pixel(WHITE);
        send_pixel(RESET_THRESHOLD);

        // A single row eight pixels wide is cut short: after six pixels the
        // width drops to four, so the next pixel, already past the new edge,
        // closes the row and with it the frame.
        configure(8, 1, RESET_THRESHOLD);
        send_pixel(BLACK);
        repeat (4) send_pixel(WHITE);
        send_pixel(BLACK);
        settle();
        set_register(REG_FRAME_WIDTH, 4);
        send_pixel(BLACK);

        // Random phases. Most use small frames with random content; a few
        // load sizes above the maximum, and one holds the box sink off long
        // enough for the block to stall its pixel input.
        phase_no     = 0;
        small_pixels = 0;
        while (phase_no < 14 || small_pixels < RANDOM_PIXELS) begin
            phase_no++;
            pix_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
            box_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 5;

            // The configuration data is wider than the threshold itself, and
            // the spare upper bits must have no effect.
            case (phase_no % 5)
                1: thr = 0;
                3: thr = 255;
                default: thr = $urandom_range(0, 255);
            endcase
            thr = thr | ($urandom_range(0, 31) << PIXEL_W);

            if (phase_no == 1) begin
                settle();
                set_register(REG_SPARE, 8191);
            end

            case (phase_no)
                2: begin
                    // Zero sizes count as one, so every pixel is a frame.
                    configure(0, 0, thr);
                    send_frames(1, 12);
                end
                4: begin
                    // Tiny frames sent flat out while the sink holds off.
                    configure(2, 2, thr);
                    pix_gap_max     = 0;
                    box_hold_cycles = HOLD_OFF;
                    send_frames(4, 30);
                end
                6: begin
                    // A width above the maximum must not end the row early.
                    // The width is then cut back, and the column counter,
                    // already past the new edge, closes the one-row frame.
                    configure(8191, 1, thr);
                    repeat (20) send_pixel(pick_pixel(300, 1'b0));
                    settle();
                    set_register(REG_FRAME_WIDTH, 8);
                    send_pixel(pick_pixel(300, 1'b0));
                end
                9: begin
                    // Likewise for the height, one pixel per row.
                    configure(1, 8191, thr);
                    repeat (20) send_pixel(pick_pixel(300, 1'b0));
                    settle();
                    set_register(REG_FRAME_HEIGHT, 8);
                    send_pixel(pick_pixel(300, 1'b0));
                end
                default: begin
                    width  = $urandom_range(1, 12);
                    height = $urandom_range(1, 6);
                    frames = $urandom_range(1, 6);
                    configure(width, height, thr);
                    send_frames(width * height, frames);
                    small_pixels += width * height * frames;
                end
            endcase
        end

        settle();
        repeat (20) @(posedge i_clk);
        if (tracker.mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
